[rtl/bsa_pkg.sv]
// Shared constants, codes and types for the bitmap slot allocator.
// No dependencies; imported by bitmap_slot_allocator, slot_grant_checker and the testbench.
package bsa_pkg;

	localparam int MAX_SLOTS  = 128;
	localparam int WORD_W     = 32;
	localparam int NUM_WORDS  = MAX_SLOTS / WORD_W;
	localparam int WORD_AW    = $clog2(NUM_WORDS);
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int SLOT_W     = 7;
	localparam int COUNT_W    = 8;
	localparam int STATUS_W   = 2;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 16;

	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [SLOT_W-1:0]   slot_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [WORD_W-1:0]   map_word_t;

	localparam logic    ACT_ALLOC = 1'b0;
	localparam logic    ACT_FREE  = 1'b1;

	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_FULL = 2'd1;
	localparam status_t ST_BAD  = 2'd2;

	localparam count_t  SLOT_COUNT_RST = 8'd100;

endpackage

[rtl/bitmap_slot_allocator.sv]
// Bitmap slot allocator: use map in a 4 x 32 word RAM, first-fit allocate, checked free.
// A request scans 1 to 4 map words, one map word read per cycle, then passes through the
// response stage; the next request waits until the result has been handed off.
// Reset: async, clears control state and per-word valid bits; no clearing pass is needed.
// Depends on bsa_pkg.
module bitmap_slot_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration: slot_count
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bsa_pkg::COUNT_W-1:0]     cfg_data,
	// request
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [bsa_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // slot_index[6:0], zero pad
	input  logic                            s_axis_tuser,  // action
	// result
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [bsa_pkg::OUT_DATA_W-1:0]  m_axis_tdata   // status, granted_index, free_count
);
	import bsa_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0]               state_q;
	logic                     action_q;
	slot_t                    idx_q;
	logic [WORD_AW-1:0]       word_addr_q;
	count_t                   used_count_q;
	count_t                   slot_count_q;
	status_t                  status_q;
	slot_t                    granted_q;
	logic                     m_valid_q;
	logic [OUT_DATA_W-1:0]    m_data_q;

	map_word_t                map_mem [NUM_WORDS];
	map_word_t                rd_data_s1;
	logic                     rd_valid_s1;
	logic [NUM_WORDS-1:0]     row_valid_q;

	logic                     accept;
	logic [WORD_AW-1:0]       rd_addr;
	logic                     wr_en;
	map_word_t                wr_data;
	count_t                   eff;
	map_word_t                cur_word;
	map_word_t                range_mask;
	map_word_t                free_mask;
	logic                     found;
	logic [BIT_W-1:0]         hit_bit;
	count_t                   next_base;
	logic                     more_words;
	logic                     free_ok;
	count_t                   span;
	count_t                   free_diff;
	slot_t                    free_count;
	logic                     out_load;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	assign eff = (slot_count_q > count_t'(MAX_SLOTS)) ? count_t'(MAX_SLOTS) : slot_count_q;
	// rows never written read as all free
	assign cur_word = rd_valid_s1 ? rd_data_s1 : '0;

	always_comb begin
		logic [SLOT_W-1:0] slot_num;
		slot_num = '0;
		for (int b = 0; b < WORD_W; b++) begin
			slot_num      = {word_addr_q, BIT_W'(b)};
			range_mask[b] = (slot_num != '0) && ({1'b0, slot_num} < eff);
		end
	end

	assign free_mask = ~cur_word & range_mask;

	always_comb begin
		found   = 1'b0;
		hit_bit = '0;
		for (int b = 0; b < WORD_W; b++) begin
			if (!found && free_mask[b]) begin
				found   = 1'b1;
				hit_bit = BIT_W'(b);
			end
		end
	end

	assign next_base  = {1'b0, word_addr_q + 1'b1, {BIT_W{1'b0}}};
	assign more_words = (word_addr_q != WORD_AW'(NUM_WORDS - 1)) && (next_base < eff);
	assign free_ok    = (idx_q != '0) && ({1'b0, idx_q} < eff) && cur_word[idx_q[BIT_W-1:0]];

	always_comb begin
		rd_addr = word_addr_q;
		wr_en   = 1'b0;
		wr_data = cur_word;
		unique case (state_q)
			S_IDLE: begin
				rd_addr = (s_axis_tuser == ACT_ALLOC) ? '0 : s_axis_tdata[SLOT_W-1:BIT_W];
			end
			S_LOOK: begin
				if (action_q == ACT_ALLOC) begin
					if (found) begin
						wr_en   = 1'b1;
						wr_data = cur_word | (map_word_t'(1) << hit_bit);
					end else if (more_words) begin
						rd_addr = word_addr_q + 1'b1;
					end
				end else if (free_ok) begin
					wr_en   = 1'b1;
					wr_data = cur_word & ~(map_word_t'(1) << idx_q[BIT_W-1:0]);
				end
			end
			S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// map RAM, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[word_addr_q] <= wr_data;
		end
		rd_data_s1 <= map_mem[rd_addr];
	end

	assign span       = (eff == '0) ? '0 : eff - 1'b1;
	assign free_diff  = span - used_count_q;
	assign free_count = (span > used_count_q) ? free_diff[SLOT_W-1:0] : '0;
	assign out_load   = (state_q == S_RESP) && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			used_count_q <= '0;
			slot_count_q <= SLOT_COUNT_RST;
			row_valid_q  <= '0;
			rd_valid_s1  <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			rd_valid_s1 <= row_valid_q[rd_addr];
			if (wr_en) begin
				row_valid_q[word_addr_q] <= 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				slot_count_q <= cfg_data;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (action_q == ACT_ALLOC) begin
						if (found) begin
							used_count_q <= used_count_q + 1'b1;
							state_q      <= S_RESP;
						end else if (!more_words) begin
							state_q <= S_RESP;
						end
					end else begin
						if (free_ok && used_count_q != '0) begin
							used_count_q <= used_count_q - 1'b1;
						end
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q    <= s_axis_tuser;
			idx_q       <= s_axis_tdata[SLOT_W-1:0];
			word_addr_q <= (s_axis_tuser == ACT_ALLOC) ? '0 : s_axis_tdata[SLOT_W-1:BIT_W];
		end else if (state_q == S_LOOK && action_q == ACT_ALLOC && !found && more_words) begin
			word_addr_q <= word_addr_q + 1'b1;
		end
		if (state_q == S_LOOK) begin
			if (action_q == ACT_ALLOC) begin
				status_q  <= found ? ST_OK : ST_FULL;
				granted_q <= found ? {word_addr_q, hit_bit} : '0;
			end else begin
				status_q  <= free_ok ? ST_OK : ST_BAD;
				granted_q <= '0;
			end
		end
		if (out_load) begin
			m_data_q <= {free_count, granted_q, status_q};
		end
	end

	a_used_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		used_count_q <= count_t'(MAX_SLOTS - 1))
		else $error("used count exceeds slot range");

	a_count_only_in_look: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(used_count_q) |-> $past(state_q) == S_LOOK)
		else $error("used count changed outside lookup");

	a_write_marks_row: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> row_valid_q[$past(word_addr_q)])
		else $error("written map row not marked valid");

	a_full_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_data_q[STATUS_W-1:0] != ST_OK
		|-> m_data_q[STATUS_W+SLOT_W-1:STATUS_W] == '0)
		else $error("granted index set on failed request");

	a_resp_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RESP && !out_load |=> state_q == S_RESP)
		else $error("response dropped under backpressure");

endmodule

[test/slot_grant_checker.sv]
// Checker for the bitmap slot allocator: watches config, request and result channels,
// keeps its own use map to predict each result and compares it field by field.
// Depends on bsa_pkg.
`timescale 1ns / 1ps

module slot_grant_checker
	import bsa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [COUNT_W-1:0]    cfg_data,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	output int                    error_count,
	output int                    outstanding
);

	localparam int REPORT_MAX = 100;

	typedef struct packed {
		status_t status;
		slot_t   granted;
		slot_t   free_cnt;
	} grant_result_t;

	logic [MAX_SLOTS-1:0] use_map;
	count_t               used_cnt;
	count_t               slot_cnt;
	grant_result_t        grant_q[$];

	initial error_count = 0;
	initial outstanding = 0;

	// Applies one request to the shadow map and returns the result it should produce.
	function automatic grant_result_t serve_request(input logic act, input slot_t idx);
		grant_result_t r;
		int eff;
		int span;
		logic found;
		r = '0;
		r.status = ST_OK;
		found = 1'b0;
		eff = (int'(slot_cnt) < MAX_SLOTS) ? int'(slot_cnt) : MAX_SLOTS;
		if (act == ACT_ALLOC) begin
			for (int i = 1; i < eff; i++) begin
				if (!found && !use_map[i]) begin
					use_map[i] = 1'b1;
					used_cnt = used_cnt + 1'b1;
					r.granted = slot_t'(i);
					found = 1'b1;
				end
			end
			if (!found)
				r.status = ST_FULL;
		end else if (idx == '0 || int'(idx) >= eff || !use_map[idx]) begin
			r.status = ST_BAD;
		end else begin
			use_map[idx] = 1'b0;
			if (used_cnt != '0)
				used_cnt = used_cnt - 1'b1;
		end
		// slots above a lowered count stay counted, so this saturates at zero
		span = (eff > 0) ? eff - 1 : 0;
		r.free_cnt = slot_t'((span > int'(used_cnt)) ? span - int'(used_cnt) : 0);
		return r;
	endfunction

	task automatic report(input string field, input int exp_v, input int got_v);
		error_count++;
		if (error_count <= REPORT_MAX)
			$error("%s mismatch: expected %0d, got %0d", field, exp_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		grant_result_t want;
		grant_result_t got;
		if (!arst_n) begin
			use_map = '0;
			used_cnt = '0;
			slot_cnt = SLOT_COUNT_RST;
			grant_q.delete();
			outstanding = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.status   = m_axis_tdata[STATUS_W-1:0];
				got.granted  = m_axis_tdata[STATUS_W +: SLOT_W];
				got.free_cnt = m_axis_tdata[STATUS_W+SLOT_W +: SLOT_W];
				if (grant_q.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_MAX)
						$error("result transaction with nothing expected: %h", m_axis_tdata);
				end else begin
					want = grant_q.pop_front();
					if (got.status !== want.status)
						report("status", want.status, got.status);
					if (got.granted !== want.granted)
						report("granted_index", want.granted, got.granted);
					if (got.free_cnt !== want.free_cnt)
						report("free_count", want.free_cnt, got.free_cnt);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				grant_q.insert(grant_q.size(),
				               serve_request(s_axis_tuser, s_axis_tdata[SLOT_W-1:0]));
			if (cfg_valid && cfg_ready)
				slot_cnt = cfg_data;
			outstanding = grant_q.size();
		end
	end

endmodule

[test/bitmap_slot_allocator_tb.sv]
// Testbench top for bitmap_slot_allocator: drives config and requests with bursty
// traffic and a stalling result side; slot_grant_checker predicts and compares.
// Depends on bsa_pkg, bitmap_slot_allocator and slot_grant_checker.
`timescale 1ns / 1ps

module bitmap_slot_allocator_tb;
	import bsa_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 8;
	localparam int NUM_PHASES   = 13;

	localparam int RX_ALWAYS = 0;
	localparam int RX_HALF   = 1;
	localparam int RX_SPARSE = 2;
	localparam int RX_MOSTLY = 3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [COUNT_W-1:0]    cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // slot_index[6:0], zero pad
	logic                  s_axis_tuser = 1'b0; // action
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;         // status, granted_index, free_count

	int     error_count;
	int     outstanding;
	int     idle_cycles = 0;
	int     burst_left = 0;
	int     rx_left = 0;
	int     rx_mode = RX_ALWAYS;
	logic   hold_req = 1'b0;
	count_t cur_count = SLOT_COUNT_RST;

	always #5 clk = ~clk;

	bitmap_slot_allocator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	slot_grant_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.error_count   (error_count),
		.outstanding   (outstanding)
	);

	// Result side: stall pattern of its own, plus one long hold-off on request.
	always begin
		@(negedge clk);
		if (hold_req) begin
			m_axis_tready <= 1'b0;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_req = 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(RX_ALWAYS, RX_MOSTLY);
				rx_left = $urandom_range(10, 80);
			end
			rx_left--;
			case (rx_mode)
				RX_ALWAYS: m_axis_tready <= 1'b1;
				RX_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_axis_tready <= ($urandom_range(0, 4) == 0);
				default:   m_axis_tready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// One request transaction; called and returns at a falling edge, valid left high.
	task automatic send_req(input logic act, input slot_t idx);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
			                                         : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_DATA_W-SLOT_W){1'b0}}, idx};
		s_axis_tuser  <= act;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		@(negedge clk);
	endtask

	// Stop offering and wait until every expected result has come out.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_slot_count(input count_t value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_count = value;
		@(negedge clk);
	endtask

	function automatic slot_t pick_slot();
		int eff;
		eff = (int'(cur_count) < MAX_SLOTS) ? int'(cur_count) : MAX_SLOTS;
		if (eff >= 2 && $urandom_range(0, 9) != 0)
			return slot_t'($urandom_range(1, eff - 1));
		return slot_t'($urandom_range(0, MAX_SLOTS - 1));
	endfunction

	int phase_count[NUM_PHASES] = '{3, 8, 17, 128, 255, 2, 64, 100, 200, 1, 33, 0, 0};
	int phase_len[NUM_PHASES]   = '{40, 60, 60, 170, 80, 30, 100, 80, 60, 20, 50, 20, 30};
	int phase_alloc[NUM_PHASES] = '{60, 65, 70, 85, 40, 60, 75, 50, 70, 60, 55, 50, 55};

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset count of 100: bad frees, first allocations, reuse of a freed slot
		send_req(ACT_FREE, 7'd0);
		send_req(ACT_FREE, 7'd5);
		send_req(ACT_FREE, 7'd127);
		send_req(ACT_ALLOC, 7'd0);
		send_req(ACT_ALLOC, 7'd127);
		send_req(ACT_ALLOC, 7'd0);
		send_req(ACT_FREE, 7'd2);
		send_req(ACT_ALLOC, 7'd0);
		send_req(ACT_FREE, 7'd99);
		send_req(ACT_FREE, 7'd100);
		// count lowered below used slots: full, out-of-range free, saturated free count
		write_slot_count(8'd2);
		send_req(ACT_ALLOC, 7'd0);
		send_req(ACT_FREE, 7'd3);
		send_req(ACT_FREE, 7'd1);
		send_req(ACT_ALLOC, 7'd0);
		// no slot in range at all
		write_slot_count(8'd0);
		send_req(ACT_ALLOC, 7'd0);
		send_req(ACT_FREE, 7'd1);
		write_slot_count(8'd1);
		send_req(ACT_ALLOC, 7'd0);
		send_req(ACT_FREE, 7'd0);
		// count above the map size clamps to it
		write_slot_count(8'd255);
		send_req(ACT_ALLOC, 7'd0);
		send_req(ACT_FREE, 7'd127);
		send_req(ACT_FREE, 7'd4);
		write_slot_count(8'd128);
		send_req(ACT_ALLOC, 7'd0);
		send_req(ACT_FREE, 7'd127);

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == NUM_PHASES - 1)
				write_slot_count(count_t'($urandom_range(0, 255)));
			else
				write_slot_count(count_t'(phase_count[p]));
			if (p == 3)
				hold_req = 1'b1;
			for (int n = 0; n < phase_len[p]; n++) begin
				if ($urandom_range(1, 100) <= phase_alloc[p])
					send_req(ACT_ALLOC, slot_t'($urandom_range(0, MAX_SLOTS - 1)));
				else
					send_req(ACT_FREE, pick_slot());
			end
		end

		drain();
		repeat (10) @(negedge clk);
		if (outstanding != 0)
			$error("%0d expected results never arrived", outstanding);
		if (error_count == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/bsa_pkg.sv
rtl/bitmap_slot_allocator.sv
test/slot_grant_checker.sv
test/bitmap_slot_allocator_tb.sv
